// File: rtl/irac_pkg.sv
package irac_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 7;
    localparam int FRAME_BITS  = 8 * FRAME_BYTES;
    localparam int SUM_BYTES   = 6;
    localparam int SUM_BITS    = 8 * SUM_BYTES;
    localparam int BIT_CNT_W   = $clog2(FRAME_BITS);

    // Durations and configuration
    localparam int DURATION_BITS_DEF = 16;
    localparam int FIELD_DUR_W       = 16;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int TOL_W             = 7;
    localparam int NUM_NOM           = 5;
    localparam int NUM_SLOT          = 2 * NUM_NOM;
    localparam int PCT_SCALE         = 100;

    localparam int QUEUE_DEPTH = 4;

    // Register indexes; the five nominal durations sit at the same places
    // in the nominal array.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HDR_MARK   = 3'd0,
        REG_HDR_SPACE  = 3'd1,
        REG_BIT_MARK   = 3'd2,
        REG_ONE_SPACE  = 3'd3,
        REG_ZERO_SPACE = 3'd4,
        REG_TOL        = 3'd5
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] RST_HDR_MARK   = 16'd6630;
    localparam logic [CFG_DATA_W-1:0] RST_HDR_SPACE  = 16'd3350;
    localparam logic [CFG_DATA_W-1:0] RST_BIT_MARK   = 16'd400;
    localparam logic [CFG_DATA_W-1:0] RST_ONE_SPACE  = 16'd1260;
    localparam logic [CFG_DATA_W-1:0] RST_ZERO_SPACE = 16'd430;
    localparam logic [TOL_W-1:0]      RST_TOL        = 7'd25;

    // Classification of one mark/space pair
    typedef enum logic [2:0] {
        CLS_HDR_OK  = 3'd0,
        CLS_HDR_BAD = 3'd1,
        CLS_ONE     = 3'd2,
        CLS_ZERO    = 3'd3,
        CLS_BAD     = 3'd4
    } pair_class_t;

    // Status codes
    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_BAD_HDR_TIMING = 3'd1;
    localparam logic [2:0] ST_BAD_BIT_TIMING = 3'd2;
    localparam logic [2:0] ST_BAD_HDR_BYTES  = 3'd3;
    localparam logic [2:0] ST_BAD_CHECKSUM   = 3'd4;

    // Frame constants
    localparam logic [7:0] HDR_BYTE0     = 8'hD3;
    localparam logic [7:0] HDR_BYTE1     = 8'h11;
    localparam logic [7:0] CHK_BASE      = 8'h7F;
    localparam logic [7:0] CHK_XOR       = 8'h2C;
    localparam logic [4:0] SETPOINT_BASE = 5'd16;

    typedef struct packed {
        logic [2:0] status;
        logic       power_on;
        logic [2:0] mode_code;
        logic [2:0] fan_code;
        logic [4:0] setpoint_c;
        logic [3:0] vane_code;
        logic       display_on;
        logic       sleep_on;
    } result_t;

    // Handshake between the front part and the queue
    typedef struct packed {
        logic        push;
        pair_class_t cls;
    } push_t;

endpackage

// File: rtl/irac_bounds.sv
module irac_bounds import irac_pkg::*; #(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_we,
    input  logic [CFG_ADDR_W-1:0]                       cfg_addr,
    input  logic [CFG_DATA_W-1:0]                       cfg_wdata,
    output logic                                        busy,
    output logic [NUM_NOM-1:0][DURATION_BITS-1:0]       lo_bound,
    output logic [NUM_NOM-1:0][DURATION_BITS+1:0]       hi_bound
);

    localparam int DW     = DURATION_BITS;
    localparam int PW     = DW + 8;
    localparam int XW     = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam int SLOT_W = $clog2(NUM_SLOT);

    // Division by the percent scale as (x * RCP_MUL) >> RCP_SHIFT, which is
    // exact for every x below 2**32.
    localparam int          RCP_SHIFT = 37;
    localparam logic [31:0] RCP_MUL   = 32'h51EB_851F;
    localparam int          QW        = RCP_SHIFT + PW;

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_MUL  = 3'b010,
        SQ_DIV  = 3'b100
    } seq_state_t;

    seq_state_t                          state_reg, state_next;
    logic [SLOT_W-1:0]                   slot_reg, slot_next;
    logic [NUM_NOM-1:0][CFG_DATA_W-1:0]  nom_reg;
    logic [TOL_W-1:0]                    tol_reg;

    logic [PW-1:0]    prod_reg;
    logic [NUM_NOM-1:0][DW-1:0]   lo_reg;
    logic [NUM_NOM-1:0][DW+1:0]   hi_reg;

    logic [XW-1:0]    nom_x;
    logic [DW-1:0]    nom;
    logic [7:0]       fac;
    logic [QW-1:0]    scaled;
    logic [PW-1:0]    quo;

    // Even slots hold the lower bound, odd slots the upper one.
    assign nom_x = XW'(nom_reg[slot_reg[SLOT_W-1:1]]);
    assign nom   = nom_x[DW-1:0];

    always_comb begin
        if (slot_reg[0]) begin
            fac = 8'(PCT_SCALE) + 8'(tol_reg);
        end else if (tol_reg >= TOL_W'(PCT_SCALE)) begin
            fac = 8'd0;
        end else begin
            fac = 8'(PCT_SCALE) - 8'(tol_reg);
        end
    end

    assign scaled = QW'(prod_reg) * QW'(RCP_MUL);
    assign quo    = scaled[QW-1 -: PW];

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            SQ_IDLE: begin
            end
            SQ_MUL: begin
                state_next = SQ_DIV;
            end
            SQ_DIV: begin
                if (slot_reg == SLOT_W'(NUM_SLOT - 1)) begin
                    state_next = SQ_IDLE;
                end else begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = SQ_MUL;
                end
            end
            default: begin
                state_next = SQ_MUL;
                slot_next  = '0;
            end
        endcase
        if (cfg_we) begin
            state_next = SQ_MUL;
            slot_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_MUL;
            slot_reg  <= '0;
            nom_reg[REG_HDR_MARK]   <= RST_HDR_MARK;
            nom_reg[REG_HDR_SPACE]  <= RST_HDR_SPACE;
            nom_reg[REG_BIT_MARK]   <= RST_BIT_MARK;
            nom_reg[REG_ONE_SPACE]  <= RST_ONE_SPACE;
            nom_reg[REG_ZERO_SPACE] <= RST_ZERO_SPACE;
            tol_reg   <= RST_TOL;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            if (cfg_we) begin
                if (cfg_addr == REG_TOL) begin
                    tol_reg <= cfg_wdata[TOL_W-1:0];
                end else if (cfg_addr < CFG_ADDR_W'(NUM_NOM)) begin
                    nom_reg[cfg_addr] <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SQ_MUL) begin
            prod_reg <= PW'(nom) * PW'(fac);
        end else if (state_reg == SQ_DIV) begin
            if (slot_reg[0]) begin
                hi_reg[slot_reg[SLOT_W-1:1]] <= quo[DW+1:0];
            end else begin
                lo_reg[slot_reg[SLOT_W-1:1]] <= quo[DW-1:0];
            end
        end
    end

    assign busy     = state_reg != SQ_IDLE;
    assign lo_bound = lo_reg;
    assign hi_bound = hi_reg;

endmodule

// File: rtl/irac_front.sv
module irac_front import irac_pkg::*; #(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_frame_start,
    input  logic [FIELD_DUR_W-1:0]                s_mark_us,
    input  logic [FIELD_DUR_W-1:0]                s_space_us,
    input  logic                                  bounds_busy,
    input  logic [NUM_NOM-1:0][DURATION_BITS-1:0] lo_bound,
    input  logic [NUM_NOM-1:0][DURATION_BITS+1:0] hi_bound,
    input  logic                                  queue_full,
    output push_t                                 push
);

    localparam int DW = DURATION_BITS;
    localparam int XW = (DW > FIELD_DUR_W) ? DW : FIELD_DUR_W;

    logic [XW-1:0] mark_x;
    logic [XW-1:0] space_x;
    logic [DW-1:0] mark;
    logic [DW-1:0] space;
    logic [NUM_NOM-1:0] mark_hit;
    logic [NUM_NOM-1:0] space_hit;
    logic hdr_ok;
    logic one_ok;
    logic zero_ok;

    assign mark_x  = XW'(s_mark_us);
    assign space_x = XW'(s_space_us);
    assign mark    = mark_x[DW-1:0];
    assign space   = space_x[DW-1:0];

    // Compare both durations against every window; only some pairs are used.
    always_comb begin
        for (int i = 0; i < NUM_NOM; i++) begin
            mark_hit[i]  = (mark >= lo_bound[i]) && ((DW+2)'(mark) <= hi_bound[i]);
            space_hit[i] = (space >= lo_bound[i]) && ((DW+2)'(space) <= hi_bound[i]);
        end
    end

    assign hdr_ok  = mark_hit[REG_HDR_MARK] && space_hit[REG_HDR_SPACE];
    assign one_ok  = mark_hit[REG_BIT_MARK] && space_hit[REG_ONE_SPACE];
    assign zero_ok = mark_hit[REG_BIT_MARK] && space_hit[REG_ZERO_SPACE];

    assign s_ready = !bounds_busy && !queue_full;

    always_comb begin
        push.push = s_valid && s_ready;
        priority if (s_frame_start) begin
            push.cls = hdr_ok ? CLS_HDR_OK : CLS_HDR_BAD;
        end else if (one_ok) begin
            push.cls = CLS_ONE;
        end else if (zero_ok) begin
            push.cls = CLS_ZERO;
        end else begin
            push.cls = CLS_BAD;
        end
    end

endmodule

// File: rtl/irac_queue.sv
module irac_queue import irac_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  push_t       push,
    output logic        full,
    output logic        pop_valid,
    output pair_class_t pop_cls,
    input  logic        pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pair_class_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign pop_valid = cnt_reg != '0;
    assign pop_cls   = mem[rd_ptr_reg];
    assign do_push   = push.push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.cls;
        end
    end

endmodule

// File: rtl/irac_back.sv
module irac_back import irac_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cls_valid,
    input  pair_class_t cls,
    output logic        cls_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_result
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BITS = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [7:0]             sum_reg, sum_next;
    logic                   m_valid_reg;
    result_t                result_reg;

    logic                   out_free;
    logic [FRAME_BITS-1:0]  frame_shift;
    logic [7:0]             chk;
    logic                   emit;
    result_t                res;
    result_t                final_res;

    assign out_free = !m_valid_reg || m_ready;
    assign cls_pop  = cls_valid && out_free;

    // Bits arrive LSB first and shift in from the top, so after the last
    // bit byte i sits at bits 8*i+7 down to 8*i.
    assign frame_shift = {cls == CLS_ONE, frame_reg[FRAME_BITS-1:1]};
    assign chk         = (CHK_BASE - sum_reg) ^ CHK_XOR;

    always_comb begin
        final_res = '0;
        if (frame_shift[7:0] != HDR_BYTE0 || frame_shift[15:8] != HDR_BYTE1) begin
            final_res.status = ST_BAD_HDR_BYTES;
        end else if (frame_shift[55:48] != chk) begin
            final_res.status = ST_BAD_CHECKSUM;
        end else begin
            final_res.status     = ST_OK;
            final_res.power_on   = frame_shift[19];
            final_res.mode_code  = frame_shift[18:16];
            final_res.fan_code   = frame_shift[22:20];
            final_res.setpoint_c = 5'(frame_shift[27:24]) + SETPOINT_BASE;
            final_res.vane_code  = frame_shift[35:32];
            final_res.display_on = frame_shift[47];
            final_res.sleep_on   = frame_shift[41];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        frame_next = frame_reg;
        sum_next   = sum_reg;
        emit       = 1'b0;
        res        = '0;
        if (cls_pop) begin
            unique case (cls)
                CLS_HDR_OK: begin
                    phase_next = PH_BITS;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
                CLS_HDR_BAD: begin
                    phase_next = PH_SKIP;
                    cnt_next   = '0;
                    emit       = 1'b1;
                    res.status = ST_BAD_HDR_TIMING;
                end
                CLS_ONE, CLS_ZERO: begin
                    if (phase_reg == PH_BITS) begin
                        frame_next = frame_shift;
                        cnt_next   = cnt_reg + 1'b1;
                        // A byte of the checksummed range completes here.
                        if (cnt_reg[2:0] == 3'b111 && cnt_reg < BIT_CNT_W'(SUM_BITS)) begin
                            sum_next = sum_reg + frame_shift[FRAME_BITS-1 -: 8];
                        end
                        if (cnt_reg == BIT_CNT_W'(FRAME_BITS - 1)) begin
                            phase_next = PH_IDLE;
                            cnt_next   = '0;
                            emit       = 1'b1;
                            res        = final_res;
                        end
                    end
                end
                CLS_BAD: begin
                    if (phase_reg == PH_BITS) begin
                        phase_next = PH_SKIP;
                        emit       = 1'b1;
                        res.status = ST_BAD_BIT_TIMING;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        sum_reg   <= sum_next;
        if (emit) begin
            result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

// File: rtl/ir_ac_frame_receiver.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_frame_start, s_mark_us, s_space_us
// m_       out        m_valid/m_ready    m_status and the decoded settings
// cfg_     in         cfg_we             cfg_addr, cfg_wdata
//
// One mark/space pair is taken per cycle while s_ready is high; a result leaves
// in the cycle after the pair completing or breaking a frame reaches the decoder.
// After reset and after every register write, the tolerance windows are
// rebuilt by one multiplier and a reciprocal multiplication for the division
// by 100, one bound at a time in a multiply and a divide state, with s_ready low.
// A stalled output holds the decoder; a four-entry queue keeps s_ready up till full.
// Reset is synchronous, active low, and restores the configuration to its defaults.
module ir_ac_frame_receiver import irac_pkg::*; #(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_frame_start,
    input  logic [FIELD_DUR_W-1:0] s_mark_us,
    input  logic [FIELD_DUR_W-1:0] s_space_us,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic                   m_power_on,
    output logic [2:0]             m_mode_code,
    output logic [2:0]             m_fan_code,
    output logic [4:0]             m_setpoint_c,
    output logic [3:0]             m_vane_code,
    output logic                   m_display_on,
    output logic                   m_sleep_on
);

    logic                                  bounds_busy;
    logic [NUM_NOM-1:0][DURATION_BITS-1:0] lo_bound;
    logic [NUM_NOM-1:0][DURATION_BITS+1:0] hi_bound;
    push_t                                 push;
    logic                                  queue_full;
    logic                                  cls_valid;
    pair_class_t                           cls;
    logic                                  cls_pop;
    result_t                               result;

    irac_bounds #(
        .DURATION_BITS(DURATION_BITS)
    ) u_bounds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .busy      (bounds_busy),
        .lo_bound  (lo_bound),
        .hi_bound  (hi_bound)
    );

    irac_front #(
        .DURATION_BITS(DURATION_BITS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_start (s_frame_start),
        .s_mark_us     (s_mark_us),
        .s_space_us    (s_space_us),
        .bounds_busy   (bounds_busy),
        .lo_bound      (lo_bound),
        .hi_bound      (hi_bound),
        .queue_full    (queue_full),
        .push          (push)
    );

    irac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (queue_full),
        .pop_valid (cls_valid),
        .pop_cls   (cls),
        .pop       (cls_pop)
    );

    irac_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_pop   (cls_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_status     = result.status;
    assign m_power_on   = result.power_on;
    assign m_mode_code  = result.mode_code;
    assign m_fan_code   = result.fan_code;
    assign m_setpoint_c = result.setpoint_c;
    assign m_vane_code  = result.vane_code;
    assign m_display_on = result.display_on;
    assign m_sleep_on   = result.sleep_on;

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input accepted while the windows are being rebuilt");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (bounds_busy || queue_full) |-> !s_ready)
        else $error("ready high while windows are stale or the queue is full");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |->
        (!m_power_on && m_mode_code == 3'd0 && m_fan_code == 3'd0 &&
         m_setpoint_c == 5'd0 && m_vane_code == 4'd0 && !m_display_on && !m_sleep_on))
        else $error("error result carries nonzero settings");

    a_ok_setpoint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> m_setpoint_c[4])
        else $error("good frame with setpoint below the base");

endmodule
